@@ src/chol_pkg.sv @@
`timescale 1ns / 1ps

package chol_pkg;

    localparam int DATA_W = 32;
    localparam int CMD_W  = 2;
    localparam int POS_W  = 3;
    localparam int STAT_W = 2;
    localparam int SIZE_W = 4;

    typedef logic [CMD_W-1:0]  cmd_t;
    typedef logic [POS_W-1:0]  pos_t;
    typedef logic [STAT_W-1:0] stat_t;
    typedef logic [SIZE_W-1:0] size_t;
    typedef logic signed [DATA_W-1:0] fx_t;

    // request commands
    localparam cmd_t CMD_WRITE_MAT = 2'd0;
    localparam cmd_t CMD_WRITE_RHS = 2'd1;
    localparam cmd_t CMD_SOLVE     = 2'd2;

    // solution status codes
    localparam stat_t STAT_OK    = 2'd0;
    localparam stat_t STAT_PIVOT = 2'd1;
    localparam stat_t STAT_SAT   = 2'd2;

    localparam fx_t FX_MAX = 32'sh7FFF_FFFF;
    localparam fx_t FX_MIN = 32'sh8000_0000;

    // saturated fixed-point value with overflow mark
    typedef struct packed {
        logic ovf;
        fx_t  val;
    } fx_res_t;

endpackage

@@ src/chol_if.sv @@
`timescale 1ns / 1ps

// request channel: one load or solve command
interface chol_req_if;
    logic            valid;
    logic            ready;
    chol_pkg::cmd_t  command;
    chol_pkg::pos_t  row;
    chol_pkg::pos_t  col;
    chol_pkg::fx_t   element_value;

    modport source (output valid, command, row, col, element_value, input ready);
    modport sink   (input valid, command, row, col, element_value, output ready);
endinterface

// solution channel: one element of x
interface chol_sol_if;
    logic            valid;
    logic            ready;
    chol_pkg::pos_t  index;
    chol_pkg::fx_t   solution_value;
    logic            last;
    chol_pkg::stat_t status;

    modport source (output valid, index, solution_value, last, status, input ready);
    modport sink   (input valid, index, solution_value, last, status, output ready);
endinterface

@@ src/cholesky_linear_solver.sv @@
`timescale 1ns / 1ps

// Channel   | Dir | Fields                                   | Handshake
// request   | in  | command, row, col, element_value         | valid/ready
// solution  | out | index, solution_value, last, status      | valid/ready
// cfg       | in  | cfg_wdata (matrix_size)                  | cfg_we, no wait
//
// Loads are taken while idle. A solve holds request ready low for its whole run:
// per column a 32-step square root and a 64-step reciprocal divide, a read,
// multiply and write per scaled entry, two reads, multiply and write per
// trailing update (about n^3/6 of them), then multiply-subtract per product
// and a 64-step divide per element, twice, on one multiplier and subtractor.
// Each result is held in the output register until the sink takes it.
// Reset (rst_n, async low) clears control and sets matrix_size to 8.
module cholesky_linear_solver #(
    parameter int MAX_N     = 8,
    parameter int FRAC_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  chol_pkg::size_t       cfg_wdata,
    chol_req_if.sink              request,
    chol_sol_if.source            solution
);

    localparam int IW = (MAX_N > 1) ? $clog2(MAX_N) : 1;
    localparam int AW = (MAX_N > 1) ? $clog2(MAX_N * MAX_N) : 1;
    localparam int CW = $clog2(MAX_N + 1);
    localparam int DEPTH = MAX_N * MAX_N;

    typedef enum logic [4:0] {
        ST_IDLE, ST_DIAG_RD, ST_SQRT_INIT, ST_SQRT_RUN, ST_SQRT_DONE,
        ST_SCL_RD, ST_SCL_MUL, ST_SCL_WR,
        ST_UPD_RD1, ST_UPD_RD2, ST_UPD_MUL, ST_UPD_WR,
        ST_SUB_INIT, ST_SUB_LOAD, ST_SUB_RD, ST_SUB_MUL, ST_SUB_ACC,
        ST_SUB_DRD, ST_SUB_DIV0, ST_DIV_RUN, ST_DIV_DONE,
        ST_OUT_RD, ST_OUT_LOAD, ST_OUT_WAIT
    } state_t;

    // ---------------------------------------------------------------
    // helpers
    function automatic chol_pkg::fx_res_t sat64(input logic signed [63:0] v);
        chol_pkg::fx_res_t r;
        if (v > 64'sh0000_0000_7FFF_FFFF) begin
            r.ovf = 1'b1;
            r.val = chol_pkg::FX_MAX;
        end
        else if (v < -64'sh0000_0000_8000_0000) begin
            r.ovf = 1'b1;
            r.val = chol_pkg::FX_MIN;
        end
        else begin
            r.ovf = 1'b0;
            r.val = v[31:0];
        end
        return r;
    endfunction

    function automatic logic [AW-1:0] m_addr(input logic [CW-1:0] r,
                                             input logic [CW-1:0] c);
        return AW'(r) * AW'(MAX_N) + AW'(c);
    endfunction

    // ---------------------------------------------------------------
    // registers
    state_t              state_reg;
    chol_pkg::size_t     size_reg;
    logic [CW-1:0]       n_reg, i_reg, j_reg, k_reg;
    logic                back_reg;
    logic                recip_reg;
    logic                piv_reg, sat_reg;
    logic [5:0]          cnt_reg;
    chol_pkg::fx_t       acc_reg, inv_reg, tmp_reg;
    logic signed [63:0]  prod_reg;
    logic [63:0]         sq_v_reg, sq_res_reg, sq_bit_reg;
    logic [63:0]         div_dvd_reg;
    logic [31:0]         div_rem_reg, div_dvs_reg;
    logic                div_neg_reg;
    logic                out_valid_reg;
    chol_pkg::pos_t      out_index_reg;
    chol_pkg::fx_t       out_value_reg;
    logic                out_last_reg;
    chol_pkg::stat_t     out_status_reg;

    // memories
    chol_pkg::fx_t       mat_mem [DEPTH];
    chol_pkg::fx_t       rhs_mem [MAX_N];
    chol_pkg::fx_t       wv_mem  [MAX_N];
    chol_pkg::fx_t       mat_q_reg, rhs_q_reg, wv_q_reg;

    logic                mat_we, rhs_we, wv_we;
    logic [AW-1:0]       mat_waddr, mat_raddr;
    logic [IW-1:0]       rhs_waddr, rhs_raddr, wv_waddr, wv_raddr;
    chol_pkg::fx_t       mat_wdata, rhs_wdata, wv_wdata;

    logic                accept;
    logic [CW:0]         i_inc, j_inc, k_inc, n_ext;
    logic [CW-1:0]       n_eff;

    assign accept = request.valid && request.ready;
    assign request.ready = (state_reg == ST_IDLE);
    assign i_inc = {1'b0, i_reg} + 1'b1;
    assign j_inc = {1'b0, j_reg} + 1'b1;
    assign k_inc = {1'b0, k_reg} + 1'b1;
    assign n_ext = {1'b0, n_reg};

    // clamp configured size to 1..MAX_N
    always_comb
    begin
        if (size_reg == '0)
            n_eff = CW'(1);
        else if (32'(size_reg) > MAX_N)
            n_eff = CW'(MAX_N);
        else
            n_eff = CW'(size_reg);
    end

    // ---------------------------------------------------------------
    // shared multiplier, rounding and subtractor
    chol_pkg::fx_t       mul_a, mul_b, sub_a;
    logic signed [63:0]  mul_p;
    chol_pkg::fx_res_t   mul_sat, sub_res;

    always_comb
    begin
        unique case (state_reg)
            ST_SCL_MUL: begin mul_a = mat_q_reg; mul_b = inv_reg;  end
            ST_UPD_MUL: begin mul_a = tmp_reg;   mul_b = mat_q_reg; end
            default:    begin mul_a = mat_q_reg; mul_b = wv_q_reg; end
        endcase
    end

    assign mul_p   = mul_a * mul_b;
    assign mul_sat = sat64(prod_reg >>> FRAC_BITS);
    assign sub_a   = (state_reg == ST_UPD_WR) ? mat_q_reg : acc_reg;
    assign sub_res = sat64(64'(sub_a) - 64'(mul_sat.val));

    // square root step
    logic [63:0] sq_sum;
    logic        sq_ge;
    assign sq_sum = sq_res_reg + sq_bit_reg;
    assign sq_ge  = (sq_v_reg >= sq_sum);

    // restoring divide step
    logic [32:0] div_sh;
    logic        div_ge;
    assign div_sh = {div_rem_reg, div_dvd_reg[63]};
    assign div_ge = (div_sh >= {1'b0, div_dvs_reg});

    // signed quotient with saturation
    chol_pkg::fx_res_t div_res;
    always_comb
    begin
        if (div_neg_reg) begin
            if (div_dvd_reg > 64'h0000_0000_8000_0000) begin
                div_res.ovf = 1'b1;
                div_res.val = chol_pkg::FX_MIN;
            end
            else begin
                div_res.ovf = 1'b0;
                div_res.val = 32'(-div_dvd_reg[31:0]);
            end
        end
        else begin
            if (div_dvd_reg > 64'h0000_0000_7FFF_FFFF) begin
                div_res.ovf = 1'b1;
                div_res.val = chol_pkg::FX_MAX;
            end
            else begin
                div_res.ovf = 1'b0;
                div_res.val = div_dvd_reg[31:0];
            end
        end
    end

    // divide operands for substitution
    logic [31:0] num_mag, den_mag;
    assign num_mag = acc_reg[31]   ? 32'(-acc_reg)   : 32'(acc_reg);
    assign den_mag = mat_q_reg[31] ? 32'(-mat_q_reg) : 32'(mat_q_reg);

    // ---------------------------------------------------------------
    // memory port control
    always_comb
    begin
        mat_we    = 1'b0;
        mat_waddr = m_addr(i_reg, i_reg);
        mat_wdata = sub_res.val;
        mat_raddr = m_addr(i_reg, i_reg);
        rhs_we    = 1'b0;
        rhs_waddr = IW'(request.row);
        rhs_wdata = request.element_value;
        rhs_raddr = i_reg[IW-1:0];
        wv_we     = 1'b0;
        wv_waddr  = i_reg[IW-1:0];
        wv_wdata  = div_res.val;
        wv_raddr  = i_reg[IW-1:0];
        unique case (state_reg)
            ST_IDLE: begin
                mat_waddr = AW'(request.row) * AW'(MAX_N) + AW'(request.col);
                mat_wdata = request.element_value;
                mat_we = accept && (request.command == chol_pkg::CMD_WRITE_MAT)
                      && (32'(request.row) < MAX_N) && (32'(request.col) < MAX_N);
                rhs_we = accept && (request.command == chol_pkg::CMD_WRITE_RHS)
                      && (32'(request.row) < MAX_N);
            end
            ST_SQRT_INIT: begin
                mat_we    = (mat_q_reg <= 0);
                mat_wdata = '0;
            end
            ST_SQRT_DONE: begin
                mat_we    = 1'b1;
                mat_wdata = sq_res_reg[31:0];
            end
            ST_SCL_RD:  mat_raddr = m_addr(j_reg, i_reg);
            ST_SCL_WR: begin
                mat_we    = 1'b1;
                mat_waddr = m_addr(j_reg, i_reg);
                mat_wdata = mul_sat.val;
            end
            ST_UPD_RD1: mat_raddr = m_addr(j_reg, i_reg);
            ST_UPD_RD2: mat_raddr = m_addr(k_reg, i_reg);
            ST_UPD_MUL: mat_raddr = m_addr(j_reg, k_reg);
            ST_UPD_WR: begin
                mat_we    = 1'b1;
                mat_waddr = m_addr(j_reg, k_reg);
            end
            ST_SUB_RD: begin
                mat_raddr = back_reg ? m_addr(j_reg, i_reg) : m_addr(i_reg, j_reg);
                wv_raddr  = j_reg[IW-1:0];
            end
            ST_DIV_DONE: wv_we = !recip_reg;
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mat_we)
            mat_mem[mat_waddr] <= mat_wdata;
        mat_q_reg <= mat_mem[mat_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (rhs_we)
            rhs_mem[rhs_waddr] <= rhs_wdata;
        rhs_q_reg <= rhs_mem[rhs_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (wv_we)
            wv_mem[wv_waddr] <= wv_wdata;
        wv_q_reg <= wv_mem[wv_raddr];
    end

    // ---------------------------------------------------------------
    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg      <= ST_IDLE;
            size_reg       <= chol_pkg::size_t'(8);
            n_reg          <= '0;
            i_reg          <= '0;
            j_reg          <= '0;
            k_reg          <= '0;
            back_reg       <= 1'b0;
            recip_reg      <= 1'b0;
            piv_reg        <= 1'b0;
            sat_reg        <= 1'b0;
            cnt_reg        <= '0;
            acc_reg        <= '0;
            inv_reg        <= '0;
            tmp_reg        <= '0;
            prod_reg       <= '0;
            sq_v_reg       <= '0;
            sq_res_reg     <= '0;
            sq_bit_reg     <= '0;
            div_dvd_reg    <= '0;
            div_rem_reg    <= '0;
            div_dvs_reg    <= '0;
            div_neg_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_index_reg  <= '0;
            out_value_reg  <= '0;
            out_last_reg   <= 1'b0;
            out_status_reg <= chol_pkg::STAT_OK;
        end
        else begin
            if (cfg_we)
                size_reg <= cfg_wdata;

            unique case (state_reg)
                ST_IDLE: begin
                    if (accept && request.command == chol_pkg::CMD_SOLVE) begin
                        n_reg     <= n_eff;
                        i_reg     <= '0;
                        piv_reg   <= 1'b0;
                        sat_reg   <= 1'b0;
                        state_reg <= ST_DIAG_RD;
                    end
                end

                // factor column i
                ST_DIAG_RD: state_reg <= ST_SQRT_INIT;

                ST_SQRT_INIT: begin
                    if (mat_q_reg <= 0) begin
                        piv_reg   <= 1'b1;
                        inv_reg   <= chol_pkg::FX_MAX;
                        j_reg     <= CW'(i_inc);
                        state_reg <= (i_inc < n_ext) ? ST_SCL_RD : ST_SUB_INIT;
                        back_reg  <= 1'b0;
                        if (!(i_inc < n_ext))
                            i_reg <= '0;
                    end
                    else begin
                        sq_v_reg   <= {32'd0, mat_q_reg} << FRAC_BITS;
                        sq_res_reg <= '0;
                        sq_bit_reg <= 64'h4000_0000_0000_0000;
                        cnt_reg    <= '0;
                        state_reg  <= ST_SQRT_RUN;
                    end
                end

                ST_SQRT_RUN: begin
                    if (sq_ge) begin
                        sq_v_reg   <= sq_v_reg - sq_sum;
                        sq_res_reg <= (sq_res_reg >> 1) + sq_bit_reg;
                    end
                    else begin
                        sq_res_reg <= sq_res_reg >> 1;
                    end
                    sq_bit_reg <= sq_bit_reg >> 2;
                    cnt_reg    <= cnt_reg + 1'b1;
                    if (cnt_reg == 6'd31)
                        state_reg <= ST_SQRT_DONE;
                end

                ST_SQRT_DONE: begin
                    div_dvd_reg <= 64'd1 << (2 * FRAC_BITS);
                    div_dvs_reg <= sq_res_reg[31:0];
                    div_rem_reg <= '0;
                    div_neg_reg <= 1'b0;
                    recip_reg   <= 1'b1;
                    cnt_reg     <= '0;
                    state_reg   <= ST_DIV_RUN;
                end

                // scale column below the diagonal
                ST_SCL_RD:  state_reg <= ST_SCL_MUL;
                ST_SCL_MUL: begin
                    prod_reg  <= mul_p;
                    state_reg <= ST_SCL_WR;
                end
                ST_SCL_WR: begin
                    sat_reg <= sat_reg | mul_sat.ovf;
                    if (j_inc < n_ext) begin
                        j_reg     <= CW'(j_inc);
                        state_reg <= ST_SCL_RD;
                    end
                    else begin
                        k_reg     <= CW'(i_inc);
                        j_reg     <= CW'(i_inc);
                        state_reg <= ST_UPD_RD1;
                    end
                end

                // trailing update M(j,k) -= M(j,i) * M(k,i)
                ST_UPD_RD1: state_reg <= ST_UPD_RD2;
                ST_UPD_RD2: begin
                    tmp_reg   <= mat_q_reg;
                    state_reg <= ST_UPD_MUL;
                end
                ST_UPD_MUL: begin
                    prod_reg  <= mul_p;
                    state_reg <= ST_UPD_WR;
                end
                ST_UPD_WR: begin
                    sat_reg <= sat_reg | mul_sat.ovf | sub_res.ovf;
                    if (j_inc < n_ext) begin
                        j_reg     <= CW'(j_inc);
                        state_reg <= ST_UPD_RD1;
                    end
                    else if (k_inc < n_ext) begin
                        k_reg     <= CW'(k_inc);
                        j_reg     <= CW'(k_inc);
                        state_reg <= ST_UPD_RD1;
                    end
                    else begin
                        i_reg     <= CW'(i_inc);
                        state_reg <= ST_DIAG_RD;
                    end
                end

                // forward / back substitution
                ST_SUB_INIT: state_reg <= ST_SUB_LOAD;
                ST_SUB_LOAD: begin
                    acc_reg <= back_reg ? wv_q_reg : rhs_q_reg;
                    if (back_reg) begin
                        j_reg     <= CW'(n_ext - 1'b1);
                        state_reg <= (n_ext - 1'b1 > {1'b0, i_reg}) ? ST_SUB_RD : ST_SUB_DRD;
                    end
                    else begin
                        j_reg     <= '0;
                        state_reg <= (i_reg != '0) ? ST_SUB_RD : ST_SUB_DRD;
                    end
                end
                ST_SUB_RD:  state_reg <= ST_SUB_MUL;
                ST_SUB_MUL: begin
                    prod_reg  <= mul_p;
                    state_reg <= ST_SUB_ACC;
                end
                ST_SUB_ACC: begin
                    acc_reg <= sub_res.val;
                    sat_reg <= sat_reg | mul_sat.ovf | sub_res.ovf;
                    if (back_reg) begin
                        j_reg     <= j_reg - 1'b1;
                        state_reg <= (j_reg - 1'b1 > i_reg) ? ST_SUB_RD : ST_SUB_DRD;
                    end
                    else begin
                        j_reg     <= CW'(j_inc);
                        state_reg <= (j_inc < {1'b0, i_reg}) ? ST_SUB_RD : ST_SUB_DRD;
                    end
                end
                ST_SUB_DRD: state_reg <= ST_SUB_DIV0;
                ST_SUB_DIV0: begin
                    recip_reg   <= 1'b0;
                    div_rem_reg <= '0;
                    div_dvs_reg <= den_mag;
                    cnt_reg     <= '0;
                    if (mat_q_reg == 0) begin
                        // zero diagonal: largest value of the numerator's sign
                        div_neg_reg <= acc_reg[31];
                        if (acc_reg > 0)
                            div_dvd_reg <= 64'h0000_0000_7FFF_FFFF;
                        else if (acc_reg < 0)
                            div_dvd_reg <= 64'h0000_0000_8000_0000;
                        else
                            div_dvd_reg <= '0;
                        state_reg <= ST_DIV_DONE;
                    end
                    else begin
                        div_neg_reg <= acc_reg[31] ^ mat_q_reg[31];
                        div_dvd_reg <= {32'd0, num_mag} << FRAC_BITS;
                        state_reg   <= ST_DIV_RUN;
                    end
                end

                // shared divider, one quotient bit per cycle
                ST_DIV_RUN: begin
                    div_rem_reg <= div_ge ? 32'(div_sh - {1'b0, div_dvs_reg})
                                          : div_sh[31:0];
                    div_dvd_reg <= {div_dvd_reg[62:0], div_ge};
                    cnt_reg     <= cnt_reg + 1'b1;
                    if (cnt_reg == 6'd63)
                        state_reg <= ST_DIV_DONE;
                end

                ST_DIV_DONE: begin
                    sat_reg <= sat_reg | div_res.ovf;
                    if (recip_reg) begin
                        inv_reg <= div_res.val;
                        j_reg   <= CW'(i_inc);
                        if (i_inc < n_ext) begin
                            state_reg <= ST_SCL_RD;
                        end
                        else begin
                            i_reg     <= '0;
                            back_reg  <= 1'b0;
                            state_reg <= ST_SUB_INIT;
                        end
                    end
                    else if (!back_reg) begin
                        if (i_inc < n_ext) begin
                            i_reg <= CW'(i_inc);
                        end
                        else begin
                            back_reg <= 1'b1;
                            i_reg    <= CW'(n_ext - 1'b1);
                        end
                        state_reg <= ST_SUB_INIT;
                    end
                    else if (i_reg == '0) begin
                        state_reg <= ST_OUT_RD;
                    end
                    else begin
                        i_reg     <= i_reg - 1'b1;
                        state_reg <= ST_SUB_INIT;
                    end
                end

                // emit solution in index order
                ST_OUT_RD: state_reg <= ST_OUT_LOAD;
                ST_OUT_LOAD: begin
                    out_valid_reg <= 1'b1;
                    out_index_reg <= chol_pkg::pos_t'(i_reg);
                    out_value_reg <= wv_q_reg;
                    out_last_reg  <= !(i_inc < n_ext);
                    if (piv_reg)
                        out_status_reg <= chol_pkg::STAT_PIVOT;
                    else if (sat_reg)
                        out_status_reg <= chol_pkg::STAT_SAT;
                    else
                        out_status_reg <= chol_pkg::STAT_OK;
                    state_reg <= ST_OUT_WAIT;
                end
                ST_OUT_WAIT: begin
                    if (solution.ready) begin
                        out_valid_reg <= 1'b0;
                        if (i_inc < n_ext) begin
                            i_reg     <= CW'(i_inc);
                            state_reg <= ST_OUT_RD;
                        end
                        else begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end

                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign solution.valid          = out_valid_reg;
    assign solution.index          = out_index_reg;
    assign solution.solution_value = out_value_reg;
    assign solution.last           = out_last_reg;
    assign solution.status         = out_status_reg;

endmodule

@@ bench/cholesky_linear_solver_tb.sv @@
`timescale 1ns / 1ps

module cholesky_linear_solver_tb;

    localparam int NMAX = 8;
    localparam int FB   = 16;
    localparam longint ONE = 64'sd1 << FB;

    // command code the block ignores
    localparam chol_pkg::cmd_t CMD_SPARE = 2'd3;

    typedef struct {
        chol_pkg::cmd_t command;
        chol_pkg::pos_t row;
        chol_pkg::pos_t col;
        chol_pkg::fx_t  value;
    } req_item_t;

    typedef struct {
        chol_pkg::pos_t  index;
        chol_pkg::fx_t   value;
        logic            last;
        chol_pkg::stat_t status;
    } sol_item_t;

    logic            clk;
    logic            rst_n;
    logic            cfg_we;
    chol_pkg::size_t cfg_wdata;

    chol_req_if rq();
    chol_sol_if sq();

    cholesky_linear_solver i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .request  (rq),
        .solution (sq)
    );

    // predictor state
    chol_pkg::fx_t   mat_copy [NMAX*NMAX];
    chol_pkg::fx_t   rhs_copy [NMAX];
    chol_pkg::fx_t   x_copy   [NMAX];
    logic [1:0]      arith_flags;
    chol_pkg::size_t size_copy;

    req_item_t pending_q [$];
    sol_item_t solution_exp_q [$];

    int  mismatches;
    int  solves_seen;
    int  results_seen;
    bit  no_idle;

    // clock and reset
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        #50ms;
        $display("CHECKS FAILED");
        $finish;
    end

    // fixed-point helpers
    function automatic chol_pkg::fx_t fx_clip(longint v);
        if (v > longint'(chol_pkg::FX_MAX))
        begin
            arith_flags[1] = 1'b1;
            return chol_pkg::FX_MAX;
        end
        if (v < longint'(chol_pkg::FX_MIN))
        begin
            arith_flags[1] = 1'b1;
            return chol_pkg::FX_MIN;
        end
        return chol_pkg::fx_t'(v);
    endfunction

    function automatic chol_pkg::fx_t fx_times(chol_pkg::fx_t a, chol_pkg::fx_t b);
        longint p;
        longint q;
        p = longint'(a) * longint'(b);
        if (p >= 0)
            q = p >>> FB;
        else
            q = -((-p + (ONE - 1)) >>> FB);
        return fx_clip(q);
    endfunction

    function automatic chol_pkg::fx_t fx_minus(chol_pkg::fx_t a, chol_pkg::fx_t b);
        return fx_clip(longint'(a) - longint'(b));
    endfunction

    function automatic chol_pkg::fx_t fx_quot(chol_pkg::fx_t num, chol_pkg::fx_t den);
        if (den == 0)
        begin
            if (num > 0) return chol_pkg::FX_MAX;
            if (num < 0) return chol_pkg::FX_MIN;
            return 0;
        end
        return fx_clip((longint'(num) * ONE) / longint'(den));
    endfunction

    function automatic chol_pkg::fx_t fx_inv(chol_pkg::fx_t r);
        if (r <= 0) return chol_pkg::FX_MAX;
        return fx_clip((64'sd1 << (2*FB)) / longint'(r));
    endfunction

    function automatic chol_pkg::fx_t fx_root(chol_pkg::fx_t a);
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] bt;
        if (a <= 0)
        begin
            arith_flags[0] = 1'b1;
            return 0;
        end
        v   = {32'b0, a} << FB;
        res = 0;
        bt  = 64'd1 << 62;
        while (bt > v) bt = bt >> 2;
        while (bt != 0)
        begin
            if (v >= res + bt)
            begin
                v   = v - (res + bt);
                res = (res >> 1) + bt;
            end
            else
                res = res >> 1;
            bt = bt >> 2;
        end
        return fx_clip(longint'(res));
    endfunction

    // factor, substitute twice, queue the n solution elements
    task automatic chol_predict_solve();
        int n;
        chol_pkg::fx_t inv;
        chol_pkg::fx_t acc;
        chol_pkg::stat_t st;
        sol_item_t e;
        n = int'(size_copy);
        if (n < 1) n = 1;
        if (n > NMAX) n = NMAX;
        arith_flags = 2'b00;
        for (int i = 0; i < n; i++)
        begin
            mat_copy[i*NMAX+i] = fx_root(mat_copy[i*NMAX+i]);
            inv = fx_inv(mat_copy[i*NMAX+i]);
            for (int j = i + 1; j < n; j++)
                mat_copy[j*NMAX+i] = fx_times(mat_copy[j*NMAX+i], inv);
            for (int k = i + 1; k < n; k++)
                for (int j = k; j < n; j++)
                    mat_copy[j*NMAX+k] = fx_minus(mat_copy[j*NMAX+k],
                        fx_times(mat_copy[j*NMAX+i], mat_copy[k*NMAX+i]));
        end
        for (int i = 0; i < n; i++)
        begin
            acc = rhs_copy[i];
            for (int j = 0; j < i; j++)
                acc = fx_minus(acc, fx_times(mat_copy[i*NMAX+j], x_copy[j]));
            x_copy[i] = fx_quot(acc, mat_copy[i*NMAX+i]);
        end
        for (int i = n - 1; i >= 0; i--)
        begin
            acc = x_copy[i];
            for (int j = n - 1; j > i; j--)
                acc = fx_minus(acc, fx_times(mat_copy[j*NMAX+i], x_copy[j]));
            x_copy[i] = fx_quot(acc, mat_copy[i*NMAX+i]);
        end
        st = arith_flags[0] ? chol_pkg::STAT_PIVOT
           : (arith_flags[1] ? chol_pkg::STAT_SAT : chol_pkg::STAT_OK);
        for (int i = 0; i < n; i++)
        begin
            e.index  = chol_pkg::pos_t'(i);
            e.value  = x_copy[i];
            e.last   = (i == n - 1);
            e.status = st;
            solution_exp_q.push_back(e);
        end
        solves_seen++;
    endtask

    task automatic chol_apply_request(req_item_t it);
        case (it.command)
            chol_pkg::CMD_WRITE_MAT: mat_copy[int'(it.row)*NMAX + int'(it.col)] = it.value;
            chol_pkg::CMD_WRITE_RHS: rhs_copy[it.row] = it.value;
            chol_pkg::CMD_SOLVE:     chol_predict_solve();
            default: ;
        endcase
    endtask

    // request driver
    int req_gap;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rq.valid         <= 1'b0;
            rq.command       <= chol_pkg::CMD_WRITE_MAT;
            rq.row           <= '0;
            rq.col           <= '0;
            rq.element_value <= '0;
            req_gap = 0;
        end
        else
        begin
            if (rq.valid && rq.ready)
            begin
                chol_apply_request('{rq.command, rq.row, rq.col, rq.element_value});
                req_gap = no_idle ? 0 : $urandom_range(0, 15);
            end
            if (!rq.valid || rq.ready)
            begin
                if (req_gap > 0)
                begin
                    req_gap--;
                    rq.valid <= 1'b0;
                end
                else if (pending_q.size() > 0)
                begin
                    req_item_t it;
                    it = pending_q.pop_front();
                    rq.valid         <= 1'b1;
                    rq.command       <= it.command;
                    rq.row           <= it.row;
                    rq.col           <= it.col;
                    rq.element_value <= it.value;
                end
                else
                    rq.valid <= 1'b0;
            end
        end
    end

    // solution monitor and ready stalls
    int sol_wait;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq.ready <= 1'b0;
            sol_wait = 0;
        end
        else
        begin
            if (sq.valid && sq.ready)
            begin
                sol_item_t e;
                results_seen++;
                if (solution_exp_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected solution index=%0d value=%0d",
                                 sq.index, sq.solution_value);
                end
                else
                begin
                    e = solution_exp_q.pop_front();
                    if (sq.index !== e.index || sq.solution_value !== e.value ||
                        sq.last !== e.last || sq.status !== e.status)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch exp idx=%0d val=%0d last=%0d st=%0d,",
                                      " got idx=%0d val=%0d last=%0d st=%0d"},
                                     e.index, e.value, e.last, e.status, sq.index,
                                     sq.solution_value, sq.last, sq.status);
                    end
                end
                sol_wait = no_idle ? 0 : $urandom_range(0, 15);
            end
            if (sol_wait > 0)
            begin
                sol_wait--;
                sq.ready <= 1'b0;
            end
            else
                sq.ready <= 1'b1;
        end
    end

    // stimulus helpers
    task automatic push_req(chol_pkg::cmd_t c, int r, int cl, chol_pkg::fx_t v);
        req_item_t it;
        it.command = c;
        it.row     = chol_pkg::pos_t'(r);
        it.col     = chol_pkg::pos_t'(cl);
        it.value   = v;
        pending_q.push_back(it);
    endtask

    // sampled away from the rising edge so driver updates have settled
    task automatic wait_idle();
        while (pending_q.size() > 0 || rq.valid || solution_exp_q.size() > 0)
            @(negedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_size(int n);
        wait_idle();
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= chol_pkg::size_t'(n);
        @(posedge clk);
        cfg_we    <= 1'b0;
        size_copy = chol_pkg::size_t'(n);
    endtask

    // diagonally dominant symmetric system, scale shifts entries up
    task automatic load_spd(int n, int scale);
        longint d;
        for (int r = 0; r < n; r++)
        begin
            for (int c = 0; c < r; c++)
                push_req(chol_pkg::CMD_WRITE_MAT, r, c,
                         chol_pkg::fx_t'(($signed($urandom_range(0, 131072)) - 65536)
                                         <<< scale));
            d = (longint'(n + 1) * ONE + $urandom_range(0, 8*65536)) <<< scale;
            push_req(chol_pkg::CMD_WRITE_MAT, r, r, fx_clip(d));
            push_req(chol_pkg::CMD_WRITE_RHS, r, 0,
                     chol_pkg::fx_t'(($signed($urandom_range(0, 1048576)) - 524288)
                                     <<< scale));
        end
    endtask

    task automatic load_noise(int n);
        for (int r = 0; r < n; r++)
        begin
            for (int c = 0; c <= r; c++)
                push_req(chol_pkg::CMD_WRITE_MAT, r, c, chol_pkg::fx_t'($urandom));
            push_req(chol_pkg::CMD_WRITE_RHS, r, $urandom_range(0, 7),
                     chol_pkg::fx_t'($urandom));
        end
    endtask

    // main sequence
    int sizes [7] = '{1, 0, 15, 3, 5, 2, 8};
    initial
    begin
        int n;
        int pick;
        cfg_we      = 1'b0;
        cfg_wdata   = '0;
        no_idle     = 1'b0;
        mismatches  = 0;
        solves_seen = 0;
        results_seen = 0;
        size_copy   = 4'd8;
        arith_flags = 2'b00;
        foreach (mat_copy[i]) mat_copy[i] = 0;
        foreach (rhs_copy[i]) rhs_copy[i] = 0;
        foreach (x_copy[i]) x_copy[i] = 0;
        @(posedge rst_n);

        // define every store entry once, identity system at reset size
        for (int r = 0; r < NMAX; r++)
        begin
            for (int c = 0; c < NMAX; c++)
                push_req(chol_pkg::CMD_WRITE_MAT, r, c,
                         (r == c) ? chol_pkg::fx_t'(ONE) : chol_pkg::fx_t'(0));
            push_req(chol_pkg::CMD_WRITE_RHS, r, 0, chol_pkg::fx_t'((r + 1) * ONE));
        end
        push_req(chol_pkg::CMD_SOLVE, 0, 0, 0);
        push_req(chol_pkg::CMD_SOLVE, 7, 7, 0);       // refactor the stored L

        // directed corners at size 1
        write_size(1);
        push_req(chol_pkg::CMD_WRITE_MAT, 0, 0, 0);   // zero pivot
        push_req(chol_pkg::CMD_WRITE_RHS, 0, 0, chol_pkg::FX_MAX);
        push_req(chol_pkg::CMD_SOLVE, 0, 0, 0);
        push_req(chol_pkg::CMD_WRITE_MAT, 0, 0, chol_pkg::FX_MIN);  // negative pivot
        push_req(chol_pkg::CMD_WRITE_RHS, 0, 0, chol_pkg::FX_MIN);
        push_req(chol_pkg::CMD_SOLVE, 0, 0, 0);
        push_req(chol_pkg::CMD_WRITE_RHS, 0, 0, 0);
        push_req(chol_pkg::CMD_SOLVE, 0, 0, 0);
        push_req(chol_pkg::CMD_WRITE_MAT, 0, 0, chol_pkg::FX_MAX);
        push_req(chol_pkg::CMD_WRITE_RHS, 0, 0, chol_pkg::FX_MAX);
        push_req(chol_pkg::CMD_SOLVE, 0, 0, 0);
        push_req(chol_pkg::CMD_WRITE_MAT, 0, 0, 32'sd1);  // tiny pivot saturates
        push_req(chol_pkg::CMD_WRITE_RHS, 0, 0, chol_pkg::FX_MAX);
        push_req(chol_pkg::CMD_SOLVE, 0, 0, 0);
        push_req(CMD_SPARE, 7, 7, chol_pkg::FX_MAX);
        push_req(CMD_SPARE, 0, 0, 0);
        push_req(chol_pkg::CMD_SOLVE, 0, 0, 0);

        // size extremes
        write_size(0);
        push_req(chol_pkg::CMD_WRITE_MAT, 0, 0, chol_pkg::fx_t'(4 * ONE));
        push_req(chol_pkg::CMD_WRITE_RHS, 0, 0, chol_pkg::fx_t'(-2 * ONE));
        push_req(chol_pkg::CMD_SOLVE, 0, 0, 0);
        write_size(15);
        load_spd(8, 0);
        push_req(chol_pkg::CMD_SOLVE, 0, 0, 0);

        // random phases
        for (int ph = 0; ph < 8; ph++)
        begin
            no_idle = (ph % 5 == 4);
            write_size((ph < 7) ? sizes[ph] : $urandom_range(0, 15));
            n = int'(size_copy);
            if (n < 1) n = 1;
            if (n > NMAX) n = NMAX;
            for (int s = 0; s < 2; s++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 65)
                    load_spd(n, ($urandom_range(0, 9) == 0) ? 8 : 0);
                else if (pick < 80)
                    load_noise(n);
                else if (pick < 90)
                    push_req(CMD_SPARE, $urandom_range(0, 7), $urandom_range(0, 7),
                             chol_pkg::fx_t'($urandom));
                push_req(chol_pkg::CMD_SOLVE, $urandom_range(0, 7), $urandom_range(0, 7),
                         chol_pkg::fx_t'($urandom));
            end
        end

        no_idle = 1'b0;
        wait_idle();
        repeat (200) @(posedge clk);
        $display("covered %0d solves, %0d solution elements,", solves_seen, results_seen);
        $display("sizes 0..15 incl. pivot and overflow cases");
        if (mismatches == 0 && solution_exp_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
